@@ rtl/fndc_pkg.sv @@
// shared widths, state codes and operand selection types for the face normal check
package fndc_pkg;

    localparam int COORD_BITS = 32;
    localparam int FACE_BITS  = 24;
    localparam int SIG_BITS   = 23;
    localparam int COS_W      = 18;
    localparam int ONE_Q16    = 65536;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int LEN_W  = SQ_W + 2;
    localparam int CR_W   = SQ_W + 1;
    localparam int RED_W  = SIG_BITS + 1;
    localparam int DOT_W  = 2 * RED_W + 2;
    localparam int HALF_W = RED_W;
    localparam int P_W    = 4 * HALF_W;
    localparam int DIV_W  = P_W + 32;
    localparam int QUO_W  = 33;
    localparam int ROOT_W = 17;

    localparam int S_TDATA_W = ((3 * COORD_BITS + FACE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COS_W + FACE_BITS + 7) / 8) * 8;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_EDGE  = 11'b00000000010,
        S_SEL   = 11'b00000000100,
        S_CROSS = 11'b00000001000,
        S_MAG   = 11'b00000010000,
        S_RED   = 11'b00000100000,
        S_DOT   = 11'b00001000000,
        S_BIG   = 11'b00010000000,
        S_DIV   = 11'b00100000000,
        S_SQRT  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic [1:0] e;
        logic [1:0] va;
        logic [1:0] vb;
        logic [1:0] comp;
    } edge_sel_t;

    function automatic edge_sel_t edge_map(input logic [3:0] op);
        edge_sel_t r;
        r = '0;
        case (op)
            4'd0: r = '{2'd0, 2'd0, 2'd1, 2'd0};
            4'd1: r = '{2'd0, 2'd0, 2'd1, 2'd1};
            4'd2: r = '{2'd0, 2'd0, 2'd1, 2'd2};
            4'd3: r = '{2'd1, 2'd1, 2'd2, 2'd0};
            4'd4: r = '{2'd1, 2'd1, 2'd2, 2'd1};
            4'd5: r = '{2'd1, 2'd1, 2'd2, 2'd2};
            4'd6: r = '{2'd2, 2'd2, 2'd0, 2'd0};
            4'd7: r = '{2'd2, 2'd2, 2'd0, 2'd1};
            4'd8: r = '{2'd2, 2'd2, 2'd0, 2'd2};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mod3(input logic [2:0] x);
        return (x >= 3'd3) ? 2'(x - 3'd3) : x[1:0];
    endfunction

endpackage

@@ rtl/face_normal_deviation_check.sv @@
// face normal deviation check: sequencer with shared multiplier, serial shift, divide and root
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | coord_x, coord_y, coord_z, face_number          | req_type, start_mesh
//  m_      | out | face_cosine, min_cosine, min_face, zero pad     | status
//
// a vertex transfer is stored straight from S_IDLE; a normal transfer closing a face
// runs 32 products on the one 33x33 multiplier, the shared right shift of up to 44
// bits, 33 restoring divide steps and 17 square root steps; a zero vector skips
// divide and root, and a normal arriving early goes straight to the result.
// reset is synchronous and active low; no input is taken while a face is in work,
// and the finished result waits in the output register until m_tready.
module face_normal_deviation_check
    import fndc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // coord_x, coord_y, coord_z, face_number
    input  logic [1:0]           s_tuser,   // req_type, start_mesh
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // face_cosine, min_cosine, min_face
    output logic                 m_tuser    // status
);

    state_t state_reg;
    logic [5:0] op_reg;
    logic       ph_reg;
    logic [1:0] count_reg;

    logic signed [COORD_BITS-1:0] vs_reg [9];
    logic signed [COORD_BITS-1:0] nv_reg [3];
    logic [FACE_BITS-1:0]         face_reg;

    logic [LEN_W-1:0]         len_reg [3];
    logic signed [DIFF_W-1:0] v1_reg [3];
    logic signed [DIFF_W-1:0] v2_reg [3];
    logic signed [CR_W-1:0]   cr_reg [3];
    logic [CR_W-1:0]          crm_reg [3];
    logic [2:0]               crn_reg;
    logic [COORD_BITS-1:0]    nm_reg [3];
    logic [2:0]               nn_neg_reg;
    logic signed [RED_W-1:0]  a_reg [3];
    logic signed [RED_W-1:0]  b_reg [3];
    logic signed [DOT_W-1:0]  dot_reg;
    logic [DOT_W-1:0]         nn_reg;
    logic [DOT_W-1:0]         mm_reg;
    logic [P_W-1:0]           p_reg;
    logic [DIV_W-1:0]         d_reg;
    logic [DIV_W-1:0]         ps_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic signed [COS_W-1:0]  cos_reg;
    logic                     status_reg;

    logic signed [COS_W-1:0] least_cos_reg;
    logic [FACE_BITS-1:0]    least_face_reg;

    logic                    m_valid_reg;
    logic                    out_status_reg;
    logic signed [COS_W-1:0] out_cos_reg;
    logic signed [COS_W-1:0] out_min_reg;
    logic [FACE_BITS-1:0]    out_face_reg;

    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [SQ_W-1:0]   prod_reg;

    edge_sel_t es;
    logic [DOT_W-1:0]  ad;
    logic [HALF_W-1:0] nn_lo, nn_hi, mm_lo, mm_hi, ad_lo, ad_hi;
    logic [1:0]        cc;

    logic [1:0] k_sel, piv_sel, k1_sel;
    logic       cr_big, n_big;
    logic       take_min;
    logic signed [COS_W-1:0] new_least;
    logic [FACE_BITS-1:0]    new_face;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_face_reg, out_min_reg, out_cos_reg});

    assign es    = edge_map(op_reg[3:0]);
    assign ad    = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
    assign nn_lo = nn_reg[HALF_W-1:0];
    assign nn_hi = nn_reg[2*HALF_W-1:HALF_W];
    assign mm_lo = mm_reg[HALF_W-1:0];
    assign mm_hi = mm_reg[2*HALF_W-1:HALF_W];
    assign ad_lo = ad[HALF_W-1:0];
    assign ad_hi = ad[2*HALF_W-1:HALF_W];
    assign cc    = op_reg[2:1];

    // shared multiplier operand selection
    always_comb begin
        logic [3:0] ia, ib;
        logic signed [DIFF_W-1:0] d;
        ia = 4'(es.va) * 4'd3 + 4'(es.comp);
        ib = 4'(es.vb) * 4'd3 + 4'(es.comp);
        d = DIFF_W'(vs_reg[ia]) - DIFF_W'(vs_reg[ib]);
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_EDGE) begin
            mul_a = d;
            mul_b = d;
        end else if (state_reg == S_CROSS) begin
            if (!op_reg[0]) begin
                mul_a = v1_reg[mod3({1'b0, cc} + 3'd1)];
                mul_b = v2_reg[mod3({1'b0, cc} + 3'd2)];
            end else begin
                mul_a = v1_reg[mod3({1'b0, cc} + 3'd2)];
                mul_b = v2_reg[mod3({1'b0, cc} + 3'd1)];
            end
        end else if (state_reg == S_DOT) begin
            case (op_reg[3:0])
                4'd0: begin mul_a = DIFF_W'(a_reg[0]); mul_b = DIFF_W'(b_reg[0]); end
                4'd1: begin mul_a = DIFF_W'(a_reg[1]); mul_b = DIFF_W'(b_reg[1]); end
                4'd2: begin mul_a = DIFF_W'(a_reg[2]); mul_b = DIFF_W'(b_reg[2]); end
                4'd3: begin mul_a = DIFF_W'(a_reg[0]); mul_b = DIFF_W'(a_reg[0]); end
                4'd4: begin mul_a = DIFF_W'(a_reg[1]); mul_b = DIFF_W'(a_reg[1]); end
                4'd5: begin mul_a = DIFF_W'(a_reg[2]); mul_b = DIFF_W'(a_reg[2]); end
                4'd6: begin mul_a = DIFF_W'(b_reg[0]); mul_b = DIFF_W'(b_reg[0]); end
                4'd7: begin mul_a = DIFF_W'(b_reg[1]); mul_b = DIFF_W'(b_reg[1]); end
                4'd8: begin mul_a = DIFF_W'(b_reg[2]); mul_b = DIFF_W'(b_reg[2]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == S_BIG) begin
            case (op_reg[2:0])
                3'd0: begin mul_a = $signed(DIFF_W'(nn_lo)); mul_b = $signed(DIFF_W'(mm_lo)); end
                3'd1: begin mul_a = $signed(DIFF_W'(nn_lo)); mul_b = $signed(DIFF_W'(mm_hi)); end
                3'd2: begin mul_a = $signed(DIFF_W'(nn_hi)); mul_b = $signed(DIFF_W'(mm_lo)); end
                3'd3: begin mul_a = $signed(DIFF_W'(nn_hi)); mul_b = $signed(DIFF_W'(mm_hi)); end
                3'd4: begin mul_a = $signed(DIFF_W'(ad_lo)); mul_b = $signed(DIFF_W'(ad_lo)); end
                3'd5: begin mul_a = $signed(DIFF_W'(ad_lo)); mul_b = $signed(DIFF_W'(ad_hi)); end
                3'd6: begin mul_a = $signed(DIFF_W'(ad_hi)); mul_b = $signed(DIFF_W'(ad_lo)); end
                3'd7: begin mul_a = $signed(DIFF_W'(ad_hi)); mul_b = $signed(DIFF_W'(ad_hi)); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // shortest edge, first on ties; pivot is the vertex opposite
    always_comb begin
        k_sel = 2'd0;
        if (len_reg[0] > len_reg[1]) k_sel = 2'd1;
        if (len_reg[k_sel] > len_reg[2]) k_sel = 2'd2;
        piv_sel = mod3({1'b0, k_sel} + 3'd2);
        k1_sel  = mod3({1'b0, k_sel} + 3'd1);
    end

    always_comb begin
        cr_big = 1'b0;
        n_big  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (crm_reg[i][CR_W-1:SIG_BITS] != '0) cr_big = 1'b1;
            if (nm_reg[i][COORD_BITS-1:SIG_BITS] != '0) n_big = 1'b1;
        end
    end

    always_comb begin
        take_min  = !status_reg && (cos_reg < least_cos_reg);
        new_least = take_min ? cos_reg : least_cos_reg;
        new_face  = take_min ? face_reg : least_face_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            ph_reg         <= 1'b0;
            count_reg      <= '0;
            least_cos_reg  <= COS_W'(ONE_Q16);
            least_face_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_DONE) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser[1]) begin
                            least_cos_reg  <= COS_W'(ONE_Q16);
                            least_face_reg <= '0;
                        end
                        if (!s_tuser[0]) begin
                            if (count_reg != 2'd3) begin
                                for (int c = 0; c < 3; c++) begin
                                    vs_reg[4'(count_reg) * 4'd3 + 4'(c)] <=
                                        s_tdata[c*COORD_BITS +: COORD_BITS];
                                end
                                count_reg <= count_reg + 2'd1;
                            end
                        end else begin
                            for (int c = 0; c < 3; c++) begin
                                nv_reg[c] <= s_tdata[c*COORD_BITS +: COORD_BITS];
                            end
                            face_reg  <= s_tdata[3*COORD_BITS +: FACE_BITS];
                            count_reg <= '0;
                            op_reg    <= '0;
                            ph_reg    <= 1'b0;
                            if (count_reg != 2'd3) begin
                                status_reg <= 1'b1;
                                cos_reg    <= '0;
                                state_reg  <= S_DONE;
                            end else begin
                                status_reg <= 1'b0;
                                for (int i = 0; i < 3; i++) len_reg[i] <= '0;
                                state_reg  <= S_EDGE;
                            end
                        end
                    end
                end
                S_EDGE: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        len_reg[es.e] <= len_reg[es.e] + LEN_W'($unsigned(prod_reg));
                        if (op_reg == 6'd8) begin
                            op_reg    <= '0;
                            state_reg <= S_SEL;
                        end else begin
                            op_reg <= op_reg + 6'd1;
                        end
                    end
                end
                S_SEL: begin
                    for (int c = 0; c < 3; c++) begin
                        v1_reg[c] <= DIFF_W'(vs_reg[4'(k_sel) * 4'd3 + 4'(c)])
                                   - DIFF_W'(vs_reg[4'(piv_sel) * 4'd3 + 4'(c)]);
                        v2_reg[c] <= DIFF_W'(vs_reg[4'(k1_sel) * 4'd3 + 4'(c)])
                                   - DIFF_W'(vs_reg[4'(piv_sel) * 4'd3 + 4'(c)]);
                        cr_reg[c] <= '0;
                    end
                    state_reg <= S_CROSS;
                end
                S_CROSS: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        if (!op_reg[0]) cr_reg[cc] <= cr_reg[cc] + CR_W'(prod_reg);
                        else            cr_reg[cc] <= cr_reg[cc] - CR_W'(prod_reg);
                        if (op_reg == 6'd5) begin
                            op_reg    <= '0;
                            state_reg <= S_MAG;
                        end else begin
                            op_reg <= op_reg + 6'd1;
                        end
                    end
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        crn_reg[i]    <= cr_reg[i][CR_W-1];
                        crm_reg[i]    <= cr_reg[i][CR_W-1] ? CR_W'(-cr_reg[i]) : CR_W'(cr_reg[i]);
                        nn_neg_reg[i] <= nv_reg[i][COORD_BITS-1];
                        nm_reg[i]     <= nv_reg[i][COORD_BITS-1] ? COORD_BITS'(-nv_reg[i])
                                                                 : COORD_BITS'(nv_reg[i]);
                    end
                    state_reg <= S_RED;
                end
                S_RED: begin
                    // one bit of shared right shift per cycle until all fit
                    for (int i = 0; i < 3; i++) begin
                        if (cr_big) crm_reg[i] <= crm_reg[i] >> 1;
                        if (n_big)  nm_reg[i]  <= nm_reg[i] >> 1;
                        a_reg[i] <= crn_reg[i] ? -$signed(RED_W'(crm_reg[i]))
                                               : $signed(RED_W'(crm_reg[i]));
                        b_reg[i] <= nn_neg_reg[i] ? -$signed(RED_W'(nm_reg[i]))
                                                  : $signed(RED_W'(nm_reg[i]));
                    end
                    if (!cr_big && !n_big) begin
                        dot_reg   <= '0;
                        nn_reg    <= '0;
                        mm_reg    <= '0;
                        state_reg <= S_DOT;
                    end
                end
                S_DOT: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        if (op_reg < 6'd3)      dot_reg <= dot_reg + DOT_W'(prod_reg);
                        else if (op_reg < 6'd6) nn_reg  <= nn_reg + DOT_W'($unsigned(prod_reg));
                        else                    mm_reg  <= mm_reg + DOT_W'($unsigned(prod_reg));
                        if (op_reg == 6'd8) begin
                            op_reg    <= '0;
                            p_reg     <= '0;
                            d_reg     <= '0;
                            state_reg <= S_BIG;
                        end else begin
                            op_reg <= op_reg + 6'd1;
                        end
                    end
                end
                S_BIG: begin
                    if (nn_reg == '0 || mm_reg == '0) begin
                        cos_reg   <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end else begin
                        ph_reg <= !ph_reg;
                        if (ph_reg) begin
                            priority case (op_reg[2:0])
                                3'd0: p_reg <= p_reg + P_W'($unsigned(prod_reg));
                                3'd1, 3'd2:
                                    p_reg <= p_reg + (P_W'($unsigned(prod_reg)) << HALF_W);
                                3'd3: p_reg <= p_reg + (P_W'($unsigned(prod_reg)) << (2*HALF_W));
                                3'd4: d_reg <= d_reg + (DIV_W'($unsigned(prod_reg)) << 32);
                                3'd5, 3'd6:
                                    d_reg <= d_reg + (DIV_W'($unsigned(prod_reg)) << (HALF_W+32));
                                default:
                                    d_reg <= d_reg
                                           + (DIV_W'($unsigned(prod_reg)) << (2*HALF_W+32));
                            endcase
                            if (op_reg == 6'd7) begin
                                op_reg    <= '0;
                                ps_reg    <= DIV_W'(p_reg) << 32;
                                quo_reg   <= '0;
                                state_reg <= S_DIV;
                            end else begin
                                op_reg <= op_reg + 6'd1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (ps_reg <= d_reg) begin
                        d_reg   <= d_reg - ps_reg;
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    ps_reg <= ps_reg >> 1;
                    if (op_reg == 6'd32) begin
                        op_reg    <= '0;
                        root_reg  <= '0;
                        state_reg <= S_SQRT;
                    end else begin
                        op_reg <= op_reg + 6'd1;
                    end
                end
                S_SQRT: begin
                    logic [ROOT_W-1:0] t;
                    logic [ROOT_W-1:0] r;
                    t = root_reg | (ROOT_W'(1) << (5'd16 - op_reg[4:0]));
                    r = ((2*ROOT_W)'(t) * (2*ROOT_W)'(t) <= (2*ROOT_W)'(quo_reg)) ? t : root_reg;
                    root_reg <= r;
                    if (op_reg == 6'd16) begin
                        cos_reg   <= dot_reg[DOT_W-1] ? -$signed(COS_W'(r)) : $signed(COS_W'(r));
                        state_reg <= S_DONE;
                    end else begin
                        op_reg <= op_reg + 6'd1;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg    <= 1'b1;
                        out_status_reg <= status_reg;
                        out_cos_reg    <= cos_reg;
                        out_min_reg    <= new_least;
                        out_face_reg   <= new_face;
                        least_cos_reg  <= new_least;
                        least_face_reg <= new_face;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
